@@ hw/rtl/apr_pkg.sv @@
`default_nettype none
package apr_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int PWM_MAX = 827;
  localparam int DRIVE_MAX_MV = 6000;

  localparam int WIN_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int MV_W = 13;
  localparam int CODE_W = 10;
  localparam int SUM_W = MV_W + $clog2(WINDOW_DEPTH + 1);
  localparam int AVG_W = MV_W + 8;
  localparam int ERR_W = AVG_W + 1;
  localparam int DERIV_W = ERR_W + 1;
  localparam int GAIN_W = 32;
  localparam int OFFSET_W = 11;
  localparam int PWM_W = 10;
  localparam int DRIVE_W = AVG_W;
  localparam int MCAND_W = 34;
  localparam int ACC_W = 66;
  localparam int CNT_W = 5;

  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;

  localparam int MV_FULL_SCALE = 6600;
  localparam int ADC_FULL_CODE = 1023;
  localparam int DRIVE_LIMIT = DRIVE_MAX_MV * 256;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FF_OFFSET = 3'd7;

  typedef struct packed {
    logic start;
    logic signed [GAIN_W-1:0] mplier;
    logic signed [MCAND_W-1:0] mcand;
    logic signed [ACC_W-1:0] init;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

@@ hw/rtl/apr_div.sv @@
`default_nettype none
module apr_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire apr_pkg::div_req_t req,
  output logic done,
  output logic [apr_pkg::DIV_NW-1:0] quotient
);

  logic [apr_pkg::DIV_DW-1:0] rem;
  logic [apr_pkg::DIV_DW-1:0] divisor;
  logic [apr_pkg::DIV_NW-1:0] num;
  logic [apr_pkg::CNT_W-1:0] count;
  logic running;
  logic [apr_pkg::DIV_DW:0] trial;
  logic fits;

  always_comb begin
    trial = {rem, num[apr_pkg::DIV_NW-1]};
    fits = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        num <= req.dividend;
        divisor <= req.divisor;
        count <= '0;
        running <= 1'b1;
      end else if (running) begin
        if (fits) begin
          rem <= apr_pkg::DIV_DW'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[apr_pkg::DIV_DW-1:0];
        end
        quotient <= {quotient[apr_pkg::DIV_NW-2:0], fits};
        num <= {num[apr_pkg::DIV_NW-2:0], 1'b0};
        count <= count + 1'b1;
        if (count == apr_pkg::CNT_W'(apr_pkg::DIV_NW - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/apr_mul.sv @@
`default_nettype none
module apr_mul (
  input  wire logic clk,
  input  wire logic rst,
  input  wire apr_pkg::mul_req_t req,
  output logic done,
  output logic signed [apr_pkg::ACC_W-1:0] acc
);

  logic [apr_pkg::GAIN_W-1:0] mplier;
  logic signed [apr_pkg::ACC_W-1:0] mcand;
  logic [apr_pkg::CNT_W-1:0] count;
  logic running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc <= req.init;
        mcand <= {{(apr_pkg::ACC_W - apr_pkg::MCAND_W){req.mcand[apr_pkg::MCAND_W-1]}},
                  req.mcand};
        mplier <= req.mplier;
        count <= '0;
        running <= 1'b1;
      end else if (running) begin
        // The top bit of the multiplier has negative weight.
        if (mplier[0]) begin
          if (count == apr_pkg::CNT_W'(apr_pkg::GAIN_W - 1)) begin
            acc <= acc - mcand;
          end else begin
            acc <= acc + mcand;
          end
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        count <= count + 1'b1;
        if (count == apr_pkg::CNT_W'(apr_pkg::GAIN_W - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/averaged_pid_pwm_regulator.sv @@
`default_nettype none
// A sample transaction is a serial division by 1023 and a window update.
// A control transaction is a serial division for the average and four bit-serial
// multiplications in one shared multiplier unit.
// One transaction is in work at a time; a waiting result does not block the next one.
// Synchronous reset restores register defaults and clears window, sum, integral and error.
module averaged_pid_pwm_regulator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic sample_valid,
  output logic sample_stall,
  input  wire logic func,
  input  wire logic [apr_pkg::CODE_W-1:0] voltage_code,
  output logic result_valid,
  input  wire logic result_stall,
  output logic [apr_pkg::PWM_W-1:0] pwm_width,
  output logic [apr_pkg::MV_W-1:0] drive_mv,
  output logic [apr_pkg::MV_W-1:0] average_mv,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [apr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SDIV, ST_CDIV, ST_INTEG, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_MUL_F, ST_RESULT
  } state_t;

  state_t state;

  logic [apr_pkg::MV_W-1:0] setpoint_mv;
  logic signed [31:0] gain_prop, gain_integ, gain_deriv, integ_upper, integ_lower, ff_gain;
  logic signed [apr_pkg::OFFSET_W-1:0] ff_offset;

  logic [apr_pkg::MV_W-1:0] sample_window [apr_pkg::WINDOW_DEPTH];
  logic [apr_pkg::WIN_AW-1:0] window_pos;
  logic [apr_pkg::SUM_W-1:0] window_sum;
  logic signed [31:0] integ_acc;
  logic signed [apr_pkg::ERR_W-1:0] last_error;
  logic signed [apr_pkg::ERR_W-1:0] err;
  logic signed [apr_pkg::DERIV_W-1:0] deriv;
  logic [apr_pkg::AVG_W-1:0] avg;
  logic [apr_pkg::DRIVE_W-1:0] drive;

  apr_pkg::div_req_t div_req;
  apr_pkg::mul_req_t mul_req;
  logic div_done, mul_done;
  logic [apr_pkg::DIV_NW-1:0] quotient;
  logic signed [apr_pkg::ACC_W-1:0] mul_acc;

  logic accept, gain_write, out_free;
  logic signed [apr_pkg::ERR_W-1:0] err_next;
  logic signed [33:0] integ_sum, integ_up, integ_lo, integ_clip;
  logic signed [31:0] integ_next;
  logic signed [apr_pkg::DERIV_W-1:0] deriv_next;
  logic [apr_pkg::DRIVE_W-1:0] drive_next;
  logic [apr_pkg::PWM_W-1:0] pwm_next;
  logic [apr_pkg::MV_W-1:0] sample_mv;

  apr_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(quotient));
  apr_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .done(mul_done), .acc(mul_acc));

  assign sample_stall = (state != ST_IDLE);
  assign accept = sample_valid && !sample_stall;
  assign cfg_ready = 1'b1;
  assign gain_write = cfg_valid && cfg_ready && (cfg_index == apr_pkg::REG_GAIN_PROP ||
                      cfg_index == apr_pkg::REG_GAIN_INTEG || cfg_index == apr_pkg::REG_GAIN_DERIV);
  assign out_free = !result_valid || !result_stall;
  assign sample_mv = quotient[apr_pkg::MV_W-1:0];

  always_comb begin
    div_req.start = accept;
    if (func) begin
      div_req.dividend = apr_pkg::DIV_NW'({window_sum, 8'b0});
      div_req.divisor = apr_pkg::DIV_DW'(apr_pkg::WINDOW_DEPTH);
    end else begin
      div_req.dividend = apr_pkg::DIV_NW'(voltage_code) * apr_pkg::DIV_NW'(apr_pkg::MV_FULL_SCALE);
      div_req.divisor = apr_pkg::DIV_DW'(apr_pkg::ADC_FULL_CODE);
    end
  end

  always_comb begin
    err_next = $signed({1'b0, setpoint_mv, 8'b0}) - $signed({1'b0, quotient[apr_pkg::AVG_W-1:0]});
    integ_sum = {{2{integ_acc[31]}}, integ_acc} +
                {{(34 - apr_pkg::ERR_W){err[apr_pkg::ERR_W-1]}}, err};
    integ_up = {{2{integ_upper[31]}}, integ_upper};
    integ_lo = {{2{integ_lower[31]}}, integ_lower};
    integ_clip = (integ_sum > integ_up) ? integ_up : integ_sum;
    if (integ_clip < integ_lo) begin
      integ_clip = integ_lo;
    end
    integ_next = integ_clip[31:0];
    deriv_next = {err[apr_pkg::ERR_W-1], err} - {last_error[apr_pkg::ERR_W-1], last_error};

    if (mul_acc[apr_pkg::ACC_W-1]) begin
      drive_next = '0;
    end else if (mul_acc[apr_pkg::ACC_W-2:16] > (apr_pkg::ACC_W - 17)'(apr_pkg::DRIVE_LIMIT)) begin
      drive_next = apr_pkg::DRIVE_W'(apr_pkg::DRIVE_LIMIT);
    end else begin
      drive_next = mul_acc[apr_pkg::DRIVE_W+15:16];
    end

    if (mul_acc[apr_pkg::ACC_W-1]) begin
      pwm_next = '0;
    end else if (mul_acc[apr_pkg::ACC_W-2:24] > (apr_pkg::ACC_W - 25)'(apr_pkg::PWM_MAX)) begin
      pwm_next = apr_pkg::PWM_W'(apr_pkg::PWM_MAX);
    end else begin
      pwm_next = mul_acc[apr_pkg::PWM_W+23:24];
    end
  end

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.mplier = gain_prop;
    mul_req.mcand = {{(apr_pkg::MCAND_W - apr_pkg::ERR_W){err[apr_pkg::ERR_W-1]}}, err};
    mul_req.init = '0;
    case (state)
      ST_INTEG: begin
        mul_req.start = 1'b1;
      end
      ST_MUL_P: begin
        mul_req.start = mul_done;
        mul_req.mplier = gain_integ;
        mul_req.mcand = {{(apr_pkg::MCAND_W - 32){integ_acc[31]}}, integ_acc};
        mul_req.init = mul_acc;
      end
      ST_MUL_I: begin
        mul_req.start = mul_done;
        mul_req.mplier = gain_deriv;
        mul_req.mcand = {{(apr_pkg::MCAND_W - apr_pkg::DERIV_W){deriv[apr_pkg::DERIV_W-1]}}, deriv};
        mul_req.init = mul_acc;
      end
      ST_MUL_D: begin
        mul_req.start = mul_done;
        mul_req.mplier = ff_gain;
        mul_req.mcand = apr_pkg::MCAND_W'(drive_next);
        mul_req.init = {{(apr_pkg::ACC_W - apr_pkg::OFFSET_W - 24){ff_offset[apr_pkg::OFFSET_W-1]}},
                        ff_offset, 24'b0};
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      result_valid <= 1'b0;
      setpoint_mv <= apr_pkg::MV_W'(5000);
      gain_prop <= 32'sd131072;
      gain_integ <= 32'sd655;
      gain_deriv <= 32'sd66;
      integ_upper <= 32'sd256000000;
      integ_lower <= -32'sd256000000;
      ff_gain <= 32'sd9023;
      ff_offset <= '0;
      for (int i = 0; i < apr_pkg::WINDOW_DEPTH; i++) begin
        sample_window[i] <= '0;
      end
      window_pos <= '0;
      window_sum <= '0;
      integ_acc <= '0;
      last_error <= '0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          apr_pkg::REG_SETPOINT: setpoint_mv <= cfg_data[apr_pkg::MV_W-1:0];
          apr_pkg::REG_GAIN_PROP: gain_prop <= cfg_data;
          apr_pkg::REG_GAIN_INTEG: gain_integ <= cfg_data;
          apr_pkg::REG_GAIN_DERIV: gain_deriv <= cfg_data;
          apr_pkg::REG_INTEG_UPPER: integ_upper <= cfg_data;
          apr_pkg::REG_INTEG_LOWER: integ_lower <= cfg_data;
          apr_pkg::REG_FF_GAIN: ff_gain <= cfg_data;
          apr_pkg::REG_FF_OFFSET: ff_offset <= cfg_data[apr_pkg::OFFSET_W-1:0];
          default: ff_offset <= ff_offset;
        endcase
        if (gain_write) begin
          integ_acc <= '0;
          last_error <= '0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= func ? ST_CDIV : ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (div_done) begin
            window_sum <= window_sum - apr_pkg::SUM_W'(sample_window[window_pos]) +
                          apr_pkg::SUM_W'(sample_mv);
            sample_window[window_pos] <= sample_mv;
            if (window_pos == apr_pkg::WIN_AW'(apr_pkg::WINDOW_DEPTH - 1)) begin
              window_pos <= '0;
            end else begin
              window_pos <= window_pos + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_CDIV: begin
          if (div_done) begin
            avg <= quotient[apr_pkg::AVG_W-1:0];
            err <= err_next;
            state <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integ_acc <= integ_next;
          deriv <= deriv_next;
          last_error <= err;
          state <= ST_MUL_P;
        end
        ST_MUL_P: if (mul_done) state <= ST_MUL_I;
        ST_MUL_I: if (mul_done) state <= ST_MUL_D;
        ST_MUL_D: begin
          if (mul_done) begin
            drive <= drive_next;
            state <= ST_MUL_F;
          end
        end
        ST_MUL_F: if (mul_done) state <= ST_RESULT;
        ST_RESULT: begin
          if (out_free) begin
            pwm_width <= pwm_next;
            drive_mv <= drive[apr_pkg::DRIVE_W-1:8];
            average_mv <= avg[apr_pkg::AVG_W-1:8];
            result_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
